@@ design/ambm_pkg.sv @@
// ----------------------------------------------------------------------------
// ambm_pkg
// Shared types and constants of the ambient light brightness mapper.
// ----------------------------------------------------------------------------
package ambm_pkg;

    // Ring of clamped samples; depth must be a power of two (mean is a shift)
    localparam int HISTORY_DEPTH = 16;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int SENS_W   = 13;
    localparam int DISP_W   = 4;
    localparam int SUM_W    = SENS_W + SLOT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Slew limit of the tracked level and its reset value
    localparam int MAX_STEP = 30;
    localparam logic [SENS_W-1:0] TRACK_RESET = SENS_W'(512);

    // Report cadence
    localparam int REP_W = 8;
    localparam logic [REP_W-1:0] REPORT_LAST = 8'hFF;

    // Mapping divider: signed difference widths and quotient steps
    localparam int SDIFF_W = SENS_W + 1;
    localparam int DDIFF_W = DISP_W + 1;
    localparam int PROD_W  = SDIFF_W + DDIFF_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int MAG_W   = NUM_W - 1;
    localparam int DEN_W   = SDIFF_W + 1;
    localparam int Q_STEPS = DISP_W;
    localparam int DIV_CNT_W = $clog2(Q_STEPS);
    localparam int LVL_W   = DISP_W + 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_LEVEL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = 3'd6;

    // Configuration register contents
    typedef struct packed {
        logic [SENS_W-1:0] sensor_min;
        logic [SENS_W-1:0] sensor_max;
        logic [DISP_W-1:0] display_min;
        logic [DISP_W-1:0] display_max;
        logic              auto_mode;
        logic [DISP_W-1:0] manual_level;
        logic              display_enable;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_TRACK,
        ST_SETUP,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_sample;
        logic update_ring;
        logic update_track;
        logic setup_div;
        logic check_div;
        logic div_step;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

@@ design/ambm_cfg.sv @@
// ----------------------------------------------------------------------------
// ambm_cfg
// Configuration register file: decodes indexed writes into the settings.
// ----------------------------------------------------------------------------
module ambm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ambm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ambm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ambm_pkg::cfg_t                    cfg
);

    ambm_pkg::cfg_t cfg_reg;
    ambm_pkg::cfg_t cfg_next;

    // Always ready: the user must write only while the block is idle; it is not enforced here
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ambm_pkg::REG_SENSOR_MIN:
                    cfg_next.sensor_min = cfg_data[ambm_pkg::SENS_W-1:0];
                ambm_pkg::REG_SENSOR_MAX:
                    cfg_next.sensor_max = cfg_data[ambm_pkg::SENS_W-1:0];
                ambm_pkg::REG_DISPLAY_MIN:
                    cfg_next.display_min = cfg_data[ambm_pkg::DISP_W-1:0];
                ambm_pkg::REG_DISPLAY_MAX:
                    cfg_next.display_max = cfg_data[ambm_pkg::DISP_W-1:0];
                ambm_pkg::REG_AUTO_MODE:
                    cfg_next.auto_mode = cfg_data[0];
                ambm_pkg::REG_MANUAL_LEVEL:
                    cfg_next.manual_level = cfg_data[ambm_pkg::DISP_W-1:0];
                ambm_pkg::REG_DISPLAY_ENABLE:
                    cfg_next.display_enable = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_min     <= ambm_pkg::SENS_W'(150);
            cfg_reg.sensor_max     <= ambm_pkg::SENS_W'(1000);
            cfg_reg.display_min    <= ambm_pkg::DISP_W'(1);
            cfg_reg.display_max    <= ambm_pkg::DISP_W'(15);
            cfg_reg.auto_mode      <= 1'b1;
            cfg_reg.manual_level   <= ambm_pkg::DISP_W'(7);
            cfg_reg.display_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/ambm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ambm_ctrl
// Sequencer: steps one sample through ring update, level tracking, the
// mapping division and the result load.
// ----------------------------------------------------------------------------
module ambm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ambm_pkg::status_t    status,
    output ambm_pkg::cmd_t       cmd
);

    ambm_pkg::state_t state_reg;
    ambm_pkg::state_t state_next;
    logic [ambm_pkg::DIV_CNT_W-1:0] step_reg;
    logic [ambm_pkg::DIV_CNT_W-1:0] step_next;

    // State and divide step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ambm_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ambm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ambm_pkg::ST_UPDATE;
                end
            end
            ambm_pkg::ST_UPDATE:
            begin
                cmd.update_ring = 1'b1;
                state_next      = ambm_pkg::ST_TRACK;
            end
            ambm_pkg::ST_TRACK:
            begin
                cmd.update_track = 1'b1;
                state_next       = ambm_pkg::ST_SETUP;
            end
            ambm_pkg::ST_SETUP:
            begin
                cmd.setup_div = 1'b1;
                state_next    = ambm_pkg::ST_CHECK;
            end
            ambm_pkg::ST_CHECK:
            begin
                cmd.check_div = 1'b1;
                step_next     = '0;
                state_next    = ambm_pkg::ST_DIVIDE;
            end
            ambm_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == ambm_pkg::DIV_CNT_W'(ambm_pkg::Q_STEPS - 1))
                begin
                    state_next = ambm_pkg::ST_FINISH;
                end
            end
            ambm_pkg::ST_FINISH:
            begin
                // Wait until the output register can take the result
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ambm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ambm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ambm_dp.sv @@
// ----------------------------------------------------------------------------
// ambm_dp
// Datapath: sample ring and running sum, slew-limited level tracking,
// linear mapping through a short restoring divider, output register.
// ----------------------------------------------------------------------------
module ambm_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ambm_pkg::cmd_t                    cmd,
    input  ambm_pkg::cfg_t                    cfg,
    input  logic [ambm_pkg::SAMPLE_W-1:0]     sample,
    output ambm_pkg::status_t                 status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ambm_pkg::DISP_W-1:0]       level,
    output logic                              level_changed,
    output logic                              display_on,
    output logic                              report_valid,
    output logic [ambm_pkg::SENS_W-1:0]       illuminance
);

    localparam int SENS_W  = ambm_pkg::SENS_W;
    localparam int DISP_W  = ambm_pkg::DISP_W;
    localparam int SUM_W   = ambm_pkg::SUM_W;
    localparam int SLOT_W  = ambm_pkg::SLOT_W;
    localparam int SDIFF_W = ambm_pkg::SDIFF_W;
    localparam int DDIFF_W = ambm_pkg::DDIFF_W;
    localparam int PROD_W  = ambm_pkg::PROD_W;
    localparam int NUM_W   = ambm_pkg::NUM_W;
    localparam int MAG_W   = ambm_pkg::MAG_W;
    localparam int DEN_W   = ambm_pkg::DEN_W;
    localparam int Q_STEPS = ambm_pkg::Q_STEPS;
    localparam int LVL_W   = ambm_pkg::LVL_W;
    localparam int REP_W   = ambm_pkg::REP_W;

    // Ring and per-sample state
    logic [ambm_pkg::SAMPLE_W-1:0] sample_reg;
    logic [SENS_W-1:0]  hist_reg [ambm_pkg::HISTORY_DEPTH];
    logic [SLOT_W-1:0]  slot_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SENS_W-1:0]  clamped;
    logic [SENS_W-1:0]  track_reg;
    logic [SENS_W-1:0]  track_next;
    logic [SENS_W-1:0]  avg_reg;
    logic [SENS_W-1:0]  avg_now;
    logic [REP_W-1:0]   rep_cnt_reg;
    logic               report_reg;

    // Divider state
    logic               neg_reg;
    logic               empty_reg;
    logic               sat_reg;
    logic [MAG_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [MAG_W-1:0]   dsh_reg;
    logic [Q_STEPS-1:0] quo_reg;

    // Output register
    logic               out_valid_reg;
    logic [DISP_W-1:0]  level_reg;
    logic               changed_reg;
    logic               display_on_reg;
    logic               report_out_reg;
    logic [SENS_W-1:0]  illum_reg;
    logic               prev_valid_reg;
    logic [DISP_W-1:0]  prev_level_reg;

    logic signed [SDIFF_W-1:0] diff;
    logic signed [SDIFF_W-1:0] diff_lim;
    logic signed [SDIFF_W-1:0] span;
    logic signed [SDIFF_W-1:0] dt;
    logic signed [DDIFF_W-1:0] dd;
    logic signed [PROD_W-1:0]  prod;
    logic signed [NUM_W-1:0]   num;
    logic signed [NUM_W-1:0]   num_abs;
    logic signed [LVL_W-1:0]   q_signed;
    logic signed [LVL_W-1:0]   v;
    logic signed [LVL_W-1:0]   lo_s;
    logic signed [LVL_W-1:0]   hi_s;
    logic [DISP_W-1:0]  lo;
    logic [DISP_W-1:0]  hi;
    logic [DISP_W-1:0]  mapped;
    logic [DISP_W-1:0]  level_next;
    logic [LVL_W-1:0]   q_ext;

    // Clamp the sample: low bound first, then high bound
    always_comb
    begin
        if ({1'b0, sample_reg} < cfg.sensor_min)
            clamped = cfg.sensor_min;
        else if ({1'b0, sample_reg} > cfg.sensor_max)
            clamped = cfg.sensor_max;
        else
            clamped = {1'b0, sample_reg};
    end

    assign sum_next = sum_reg - SUM_W'(hist_reg[slot_reg]) + SUM_W'(clamped);

    // Truncated mean of the ring
    assign avg_now = sum_reg[SUM_W-1:SLOT_W];

    // Slew-limit the tracked level toward the mean
    always_comb
    begin
        diff = $signed({1'b0, avg_now}) - $signed({1'b0, track_reg});
        if (diff > SDIFF_W'(ambm_pkg::MAX_STEP))
            diff_lim = SDIFF_W'(ambm_pkg::MAX_STEP);
        else if (diff < -SDIFF_W'(ambm_pkg::MAX_STEP))
            diff_lim = -SDIFF_W'(ambm_pkg::MAX_STEP);
        else
            diff_lim = diff;
        track_next = SENS_W'($signed({1'b0, track_reg}) + diff_lim);
    end

    // Numerator and denominator of the rounded mapping
    always_comb
    begin
        span    = $signed({1'b0, cfg.sensor_max}) - $signed({1'b0, cfg.sensor_min});
        dt      = $signed({1'b0, track_reg}) - $signed({1'b0, cfg.sensor_min});
        dd      = $signed({1'b0, cfg.display_max}) - $signed({1'b0, cfg.display_min});
        prod    = PROD_W'(dd) * PROD_W'(dt);
        num     = (NUM_W'(prod) <<< 1) + NUM_W'(span);
        num_abs = (num < 0) ? -num : num;
    end

    // Finish: signed floor quotient, offset, saturate, select the mode
    always_comb
    begin
        lo    = (cfg.display_min < cfg.display_max) ? cfg.display_min : cfg.display_max;
        hi    = (cfg.display_min < cfg.display_max) ? cfg.display_max : cfg.display_min;
        lo_s  = $signed({2'b00, lo});
        hi_s  = $signed({2'b00, hi});
        q_ext = {2'b00, quo_reg};
        if (neg_reg)
            q_signed = -$signed(q_ext + LVL_W'(rem_reg != '0));
        else
            q_signed = $signed(q_ext);
        v = $signed({2'b00, cfg.display_min}) + q_signed;
        if (sat_reg)
            mapped = neg_reg ? lo : hi;
        else if (v < lo_s)
            mapped = lo;
        else if (v > hi_s)
            mapped = hi;
        else
            mapped = v[DISP_W-1:0];
        if (!cfg.auto_mode)
            level_next = cfg.manual_level;
        else if (empty_reg)
            level_next = cfg.display_min;
        else
            level_next = mapped;
    end

    // Capture the sample on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= sample;
    end

    // Ring, running sum, tracked level, report timing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ambm_pkg::HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
            slot_reg    <= '0;
            sum_reg     <= '0;
            track_reg   <= ambm_pkg::TRACK_RESET;
            rep_cnt_reg <= '0;
            report_reg  <= 1'b0;
            avg_reg     <= '0;
        end
        else
        begin
            if (cmd.update_ring)
            begin
                hist_reg[slot_reg] <= clamped;
                sum_reg            <= sum_next;
                slot_reg           <= slot_reg + 1'b1;
            end
            if (cmd.update_track)
            begin
                avg_reg    <= avg_now;
                track_reg  <= track_next;
                report_reg <= (rep_cnt_reg == ambm_pkg::REPORT_LAST);
                if (rep_cnt_reg == ambm_pkg::REPORT_LAST)
                    rep_cnt_reg <= REP_W'(1);
                else
                    rep_cnt_reg <= rep_cnt_reg + 1'b1;
            end
        end
    end

    // Mapping divider: setup, saturation check, one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.setup_div)
        begin
            neg_reg   <= (num < 0);
            empty_reg <= (span <= 0);
            rem_reg   <= num_abs[MAG_W-1:0];
            den_reg   <= DEN_W'({span, 1'b0});
        end
        if (cmd.check_div)
        begin
            sat_reg <= ({1'b0, rem_reg} >= (NUM_W'(den_reg) << Q_STEPS));
            dsh_reg <= MAG_W'(den_reg) << (Q_STEPS - 1);
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[Q_STEPS-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[Q_STEPS-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Output register: load on finish, drop when the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_level_reg <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg  <= 1'b1;
                prev_valid_reg <= 1'b1;
                prev_level_reg <= level_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            level_reg      <= level_next;
            changed_reg    <= !prev_valid_reg || (level_next != prev_level_reg);
            display_on_reg <= cfg.display_enable;
            report_out_reg <= report_reg;
            illum_reg      <= avg_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign level           = level_reg;
    assign level_changed   = changed_reg;
    assign display_on      = display_on_reg;
    assign report_valid    = report_out_reg;
    assign illuminance     = illum_reg;

endmodule

@@ design/ambient_light_brightness_mapper.sv @@
// ----------------------------------------------------------------------------
// ambient_light_brightness_mapper
// Maps light-sensor samples to a display brightness level: clamp, moving
// average over a 16-entry ring, slew-limited tracking, rounded linear map.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   sample
//   out      output     out_valid / out_stall level, level_changed, display_on,
//                                             report_valid, illuminance
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample passes through the accept step, ring update, tracking,
// divider setup, saturation check, 4 quotient steps of the mapping divider
// and the result load; the next sample is accepted in the following cycle.
// Reset clears the ring flip-flops directly; no clearing pass is needed.
// A result waits in the output register while out_stall is high; the
// sequencer then holds in its last step and keeps in_stall high.
// ----------------------------------------------------------------------------
module ambient_light_brightness_mapper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ambm_pkg::SAMPLE_W-1:0]     sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ambm_pkg::DISP_W-1:0]       level,
    output logic                              level_changed,
    output logic                              display_on,
    output logic                              report_valid,
    output logic [ambm_pkg::SENS_W-1:0]       illuminance,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ambm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ambm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ambm_pkg::cfg_t    cfg;
    ambm_pkg::cmd_t    cmd;
    ambm_pkg::status_t status;

    ambm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ambm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ambm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .sample        (sample),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .level_changed (level_changed),
        .display_on    (display_on),
        .report_valid  (report_valid),
        .illuminance   (illuminance)
    );

endmodule
